// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/rhwa_pkg.sv -----
// ----------------------------------------------------------------------------
// rhwa_pkg
// Widths, command codes and inter-module structs of the rate history block.
// ----------------------------------------------------------------------------
package rhwa_pkg;

  localparam int DATA_W = 64;
  localparam int WIN_W  = 7;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // top -> history store
  typedef struct packed {
    logic              add;
    logic              clear;
    logic              start;
    logic [WIN_W-1:0]  window;
    logic [DATA_W-1:0] sample;
  } hist_ctrl_t;

  // history store -> top
  typedef struct packed {
    logic              sum_valid;
    logic [DATA_W-1:0] sum;
  } hist_stat_t;

  // top -> divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [WIN_W-1:0]  divisor;
  } div_ctrl_t;

  // divider -> top
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_stat_t;

endpackage

// ----- rtl/rhwa_if.sv -----
// ----------------------------------------------------------------------------
// rhwa_if
// Request and response channels (valid/ready) of the rate history block.
// ----------------------------------------------------------------------------
interface rhwa_req_if;
  logic                         valid;
  logic                         ready;
  logic [rhwa_pkg::CMD_W-1:0]   cmd;
  logic [rhwa_pkg::DATA_W-1:0]  sample;
  logic [rhwa_pkg::WIN_W-1:0]   window;

  modport source (output valid, output cmd, output sample, output window, input ready);
  modport sink   (input valid, input cmd, input sample, input window, output ready);
endinterface

interface rhwa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rhwa_pkg::DATA_W-1:0]  average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ----- rtl/rhwa_hist.sv -----
// ----------------------------------------------------------------------------
// rhwa_hist
// Circular sample store with a backward walk that accumulates the window sum.
// ----------------------------------------------------------------------------
module rhwa_hist #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rhwa_pkg::hist_ctrl_t ctrl,
  output rhwa_pkg::hist_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [rhwa_pkg::DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]                wp;
  logic [FW-1:0]                fill;      // slots written since clear
  logic [AW-1:0]                rd_idx;
  logic [rhwa_pkg::WIN_W-1:0]   left;
  logic [FW-1:0]                vleft;     // written slots still ahead
  logic                         walking;
  logic                         pend;
  logic                         pend_tag;
  logic                         pend_last;
  logic [rhwa_pkg::DATA_W-1:0]  rd_data;
  logic [rhwa_pkg::DATA_W-1:0]  sum;
  logic                         done;

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] idx);
    step_back = (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

  // storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.add) begin
      mem[wp] <= ctrl.sample;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctrl.clear) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctrl.add) begin
      wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (fill != FW'(DEPTH)) begin
        fill <= fill + FW'(1);
      end
    end
  end

  // walk: issue one read a cycle, accumulate each word in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= pend && pend_last;
      pend <= walking;
      if (ctrl.start) begin
        walking <= 1'b1;
      end else if (walking && left == rhwa_pkg::WIN_W'(1)) begin
        walking <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rd_idx <= step_back(wp);
      left   <= ctrl.window;
      vleft  <= fill;
      sum    <= '0;
    end else begin
      if (walking) begin
        rd_idx <= step_back(rd_idx);
        left   <= left - rhwa_pkg::WIN_W'(1);
        if (vleft != '0) begin
          vleft <= vleft - FW'(1);
        end
      end
      if (pend && pend_tag) begin
        sum <= sum + rd_data;
      end
    end
    pend_tag  <= (vleft != '0);
    pend_last <= (left == rhwa_pkg::WIN_W'(1));
  end

  assign stat.sum_valid = done;
  assign stat.sum       = sum;

endmodule

// ----- rtl/rhwa_div.sv -----
// ----------------------------------------------------------------------------
// rhwa_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module rhwa_div (
  input  logic                clk,
  input  logic                rst,
  input  rhwa_pkg::div_ctrl_t ctrl,
  output rhwa_pkg::div_stat_t stat
);

  localparam int DW    = rhwa_pkg::DATA_W;
  localparam int VW    = rhwa_pkg::WIN_W;
  localparam int CNT_W = $clog2(DW);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    quo;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dsr;

  logic [VW:0]      shifted;
  logic [VW:0]      diff;
  logic             ge;

  // remainder stays below the divisor, so one compare-subtract per bit
  always_comb begin
    shifted = {rem, quo[DW-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(DW - 1));
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= ctrl.dividend;
      rem <= '0;
      dsr <= ctrl.divisor;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : shifted[VW-1:0];
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

// ----- rtl/rate_history_window_average_top.sv -----
// ----------------------------------------------------------------------------
// rate_history_window_average_top
// Moving average over a circular history of 64-bit rate samples.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink)  : cmd, sample, window. cmd add stores sample at the write
//                 pointer, cmd clear empties the history, cmd query asks for
//                 the truncated mean of the newest window samples.
//   rsp (source): average, one response per query only; adds, clears and
//                 the unused code produce no response.
//   Add and clear leave the sequencer idle; req.ready stays high behind them.
//   A query walks the store one slot per cycle, then runs the bit-serial
//   divider, then loads the output register. A window of zero or above
//   DEPTH answers 0 without the walk or the divider, through the output
//   register. req.ready is low while a query is in flight, since the store
//   has a single read port and the divider works one bit a cycle.
//   The response sits in an output register: further adds and clears are
//   taken while it waits; a new query finishes its work and then waits for
//   the old response to be taken.
//   Reset: history reads as empty (all zero) at once, no clearing pass; a
//   fill count marks which slots were written since reset or clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rate_history_window_average_top #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  rhwa_req_if.sink          req,
  rhwa_rsp_if.source        rsp
);

  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CMP_W = ((FW > rhwa_pkg::WIN_W) ? FW : rhwa_pkg::WIN_W) + 1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [rhwa_pkg::WIN_W-1:0]   win_q;
  logic [rhwa_pkg::DATA_W-1:0]  res;
  logic                         out_valid;
  logic [rhwa_pkg::DATA_W-1:0]  out_avg;

  logic                         fire;
  logic                         win_ok;
  logic                         bad_query;
  logic                         out_free;

  rhwa_pkg::hist_ctrl_t         hist_ctrl;
  rhwa_pkg::hist_stat_t         hist_st;
  rhwa_pkg::div_ctrl_t          div_ctrl;
  rhwa_pkg::div_stat_t          div_st;

  assign req.ready = (state == S_IDLE);
  assign fire      = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // window must be 1..DEPTH
  assign win_ok = (req.window != '0) && (CMP_W'(req.window) <= CMP_W'(DEPTH));

  // query with a window outside 1..DEPTH answers 0 without walking
  assign bad_query = fire && (req.cmd == rhwa_pkg::CMD_QUERY) && !win_ok;

  always_comb begin
    hist_ctrl.add    = fire && (req.cmd == rhwa_pkg::CMD_ADD);
    hist_ctrl.clear  = fire && (req.cmd == rhwa_pkg::CMD_CLEAR);
    hist_ctrl.start  = fire && (req.cmd == rhwa_pkg::CMD_QUERY) && win_ok;
    hist_ctrl.window = req.window;
    hist_ctrl.sample = req.sample;

    div_ctrl.start    = hist_st.sum_valid;
    div_ctrl.dividend = hist_st.sum;
    div_ctrl.divisor  = win_q;
  end

  rhwa_hist #(
    .DEPTH (DEPTH)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .ctrl (hist_ctrl),
    .stat (hist_st)
  );

  rhwa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_st)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (fire && req.cmd == rhwa_pkg::CMD_QUERY) begin
          state_next = win_ok ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (hist_st.sum_valid) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query payload: divisor and result
  always_ff @(posedge clk) begin
    if (fire) begin
      win_q <= req.window;
    end
    if (bad_query) begin
      res <= '0;
    end else if (state == S_DIV && div_st.done) begin
      res <= div_st.quotient;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_avg <= res;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.average = out_avg;

  // checks
  `ASSERT_IMPLY(a_sum_in_walk, clk, rst, hist_st.sum_valid, state == S_WALK)
  `ASSERT_IMPLY(a_div_in_div, clk, rst, div_st.done, state == S_DIV)
  `ASSERT_NEXT(a_bad_win_zero, clk, rst, bad_query, state == S_DONE && res == '0)
  `ASSERT_NEXT(a_done_loads, clk, rst, state == S_DONE && out_free, rsp.valid && state == S_IDLE)

endmodule

// ----- verif/rate_history_window_average_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_history_window_average_top_tb
// Self-checking bench for the rate history moving average block. Requests
// (add / query / clear / unused code) go in through the request channel.
// A shadow copy of the sample ring and the write pointer works out the mean
// each query should return. Responses are checked in order against that
// list. A directed table runs first, then about 1900 random requests, with
// bursty request traffic and a response side that stalls on its own pattern.
// ----------------------------------------------------------------------------
module rate_history_window_average_top_tb;

  localparam int DEPTH = 64;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int DRAIN_CYCLES = 150;   // a bit over the full-window query latency
  localparam int TABLE_ROWS = 25;

  // cmd 3 has no meaning; the block must ignore it
  localparam logic [rhwa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [rhwa_pkg::DATA_W-1:0] ALL_ONES = {rhwa_pkg::DATA_W{1'b1}};
  localparam logic [rhwa_pkg::DATA_W-1:0] TOP_BIT  =
    {1'b1, {(rhwa_pkg::DATA_W-1){1'b0}}};

  logic clk;
  logic rst;

  rhwa_req_if req ();
  rhwa_rsp_if rsp ();

  rate_history_window_average_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow state: sample ring, write pointer, and the averages still owed
  // by the block in query order.
  // --------------------------------------------------------------------------
  logic [rhwa_pkg::DATA_W-1:0] rate_hist [DEPTH];
  logic [5:0]                  hist_wp;
  logic [rhwa_pkg::DATA_W-1:0] owed_averages [$];
  int                          failures;

  // Truncated mean of the newest w samples, walking back from the slot just
  // written. The sum wraps at 64 bits on purpose. Bad windows give 0.
  function automatic logic [rhwa_pkg::DATA_W-1:0] window_mean(
    input logic [rhwa_pkg::WIN_W-1:0] w);
    logic [rhwa_pkg::DATA_W-1:0] sum;
    logic [5:0]                  idx;
    sum = '0;
    if (w == 0 || w > DEPTH) return '0;
    idx = hist_wp - 6'd1;
    for (int k = 0; k < w; k++) begin
      sum = sum + rate_hist[idx];
      idx = idx - 6'd1;
    end
    return sum / {{(rhwa_pkg::DATA_W-rhwa_pkg::WIN_W){1'b0}}, w};
  endfunction

  // Apply one accepted request to the shadow state. For rows whose answer is
  // typed into the table, that value is queued instead of the computed one.
  task automatic track_request(input logic [rhwa_pkg::CMD_W-1:0] c,
                               input logic [rhwa_pkg::DATA_W-1:0] s,
                               input logic [rhwa_pkg::WIN_W-1:0] w, input bit typed,
                               input logic [rhwa_pkg::DATA_W-1:0] typed_avg);
    case (c)
      rhwa_pkg::CMD_ADD: begin
        rate_hist[hist_wp] = s;
        hist_wp = hist_wp + 6'd1;      // DEPTH is 64, so the 6-bit pointer wraps itself
      end
      rhwa_pkg::CMD_QUERY: begin
        if (typed) owed_averages.push_back(typed_avg);
        else owed_averages.push_back(window_mean(w));
      end
      rhwa_pkg::CMD_CLEAR: begin
        for (int k = 0; k < DEPTH; k++) rate_hist[k] = '0;
        hist_wp = '0;
      end
      default: ;                       // unused code: no effect, no response
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request side. valid stays high across back-to-back requests; it only
  // drops when the burst runs out and a gap is taken, or during a drain.
  // --------------------------------------------------------------------------
  int burst_left;

  task automatic send_request(input logic [rhwa_pkg::CMD_W-1:0] c,
                              input logic [rhwa_pkg::DATA_W-1:0] s,
                              input logic [rhwa_pkg::WIN_W-1:0] w, input bit typed,
                              input logic [rhwa_pkg::DATA_W-1:0] typed_avg);
    req.valid  <= 1'b1;
    req.cmd    <= c;
    req.sample <= s;
    req.window <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    track_request(c, s, w, typed, typed_avg);
  endtask

  // Called after each accepted request: end of burst means a random gap.
  // A gap of zero keeps the stream going, which gives long unbroken stretches.
  task automatic pace_requests();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Hold the request side until every owed response has come back.
  task automatic drain_responses();
    req.valid <= 1'b0;
    @(posedge clk);
    while (owed_averages.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready steps through four behaviors in turn. Always ready,
  // coin flip, mostly stalled, and a fixed 3-of-8 pattern.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cyc;
    cyc = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      case ((cyc >> 8) % 4)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= 1'($urandom_range(0, 1));
        2: rsp.ready <= ($urandom_range(0, 3) == 0);
        default: rsp.ready <= (cyc % 8) < 3;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: every accepted response is matched against the oldest
  // owed average.
  // --------------------------------------------------------------------------
  logic [rhwa_pkg::DATA_W-1:0] want_avg;

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (owed_averages.size() == 0) begin
        $display("%0t: response with no query outstanding: expected none, actual %h",
                 $time, rsp.average);
        failures++;
      end else begin
        want_avg = owed_averages.pop_front();
        if (rsp.average !== want_avg) begin
          $display("%0t: average mismatch: expected %h, actual %h",
                   $time, want_avg, rsp.average);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. typed=1 rows carry an answer that is obvious at a glance
  // (empty history, bad window, one known sample); the rest are left to
  // the shadow model.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [rhwa_pkg::CMD_W-1:0]  cmd;
    logic [rhwa_pkg::DATA_W-1:0] sample;
    logic [rhwa_pkg::WIN_W-1:0]  window;
    logic                        typed;
    logic [rhwa_pkg::DATA_W-1:0] average;
  } request_row_t;

  request_row_t directed_rows [TABLE_ROWS];

  initial begin
    // empty history right out of reset
    directed_rows[0]  = '{rhwa_pkg::CMD_QUERY, '0,       7'd64,  1'b1, '0};
    directed_rows[1]  = '{rhwa_pkg::CMD_QUERY, '0,       7'd1,   1'b1, '0};
    // zero window and windows past the depth
    directed_rows[2]  = '{rhwa_pkg::CMD_QUERY, '0,       7'd0,   1'b1, '0};
    directed_rows[3]  = '{rhwa_pkg::CMD_QUERY, '0,       7'd65,  1'b1, '0};
    directed_rows[4]  = '{rhwa_pkg::CMD_QUERY, '0,       7'd127, 1'b1, '0};
    // unused code with every payload bit set must leave the ring untouched
    directed_rows[5]  = '{CMD_UNUSED,          ALL_ONES, 7'd127, 1'b0, '0};
    directed_rows[6]  = '{rhwa_pkg::CMD_QUERY, '0,       7'd1,   1'b1, '0};
    // two max samples: the sum wraps
    directed_rows[7]  = '{rhwa_pkg::CMD_ADD,   ALL_ONES, 7'd0,   1'b0, '0};
    directed_rows[8]  = '{rhwa_pkg::CMD_ADD,   ALL_ONES, 7'd127, 1'b0, '0};
    directed_rows[9]  = '{rhwa_pkg::CMD_QUERY, ALL_ONES, 7'd2,   1'b0, '0};
    directed_rows[10] = '{rhwa_pkg::CMD_QUERY, '0,       7'd1,   1'b1, ALL_ONES};
    directed_rows[11] = '{rhwa_pkg::CMD_ADD,   '0,       7'd0,   1'b0, '0};
    directed_rows[12] = '{rhwa_pkg::CMD_QUERY, '0,       7'd3,   1'b0, '0};
    directed_rows[13] = '{rhwa_pkg::CMD_ADD,   TOP_BIT,  7'd0,   1'b0, '0};
    directed_rows[14] = '{rhwa_pkg::CMD_ADD,   64'd1,    7'd0,   1'b0, '0};
    // full window with mostly unwritten slots
    directed_rows[15] = '{rhwa_pkg::CMD_QUERY, '0,       7'd64,  1'b0, '0};
    directed_rows[16] = '{rhwa_pkg::CMD_QUERY, ALL_ONES, 7'd0,   1'b1, '0};
    directed_rows[17] = '{rhwa_pkg::CMD_QUERY, '0,       7'd65,  1'b1, '0};
    // clear empties everything and rewinds the pointer
    directed_rows[18] = '{rhwa_pkg::CMD_CLEAR, ALL_ONES, 7'd127, 1'b0, '0};
    directed_rows[19] = '{rhwa_pkg::CMD_QUERY, '0,       7'd64,  1'b1, '0};
    directed_rows[20] = '{rhwa_pkg::CMD_ADD,   64'h0123_4567_89ab_cdef, 7'd0, 1'b0, '0};
    directed_rows[21] = '{rhwa_pkg::CMD_QUERY, '0,       7'd1,   1'b1,
                          64'h0123_4567_89ab_cdef};
    directed_rows[22] = '{rhwa_pkg::CMD_ADD,   64'hfedc_ba98_7654_3210, 7'd0, 1'b0, '0};
    directed_rows[23] = '{rhwa_pkg::CMD_QUERY, '0,       7'd2,   1'b0, '0};
    directed_rows[24] = '{rhwa_pkg::CMD_CLEAR, '0,       7'd0,   1'b0, '0};
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                          sent;
    int unsigned                 pick;
    logic [rhwa_pkg::CMD_W-1:0]  c;
    logic [rhwa_pkg::DATA_W-1:0] s;
    logic [rhwa_pkg::WIN_W-1:0]  w;

    failures   = 0;
    burst_left = 1;
    hist_wp    = '0;
    for (int k = 0; k < DEPTH; k++) rate_hist[k] = '0;

    rst        <= 1'b1;
    req.valid  <= 1'b0;
    req.cmd    <= rhwa_pkg::CMD_ADD;
    req.sample <= '0;
    req.window <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int r = 0; r < TABLE_ROWS; r++) begin
      send_request(directed_rows[r].cmd, directed_rows[r].sample,
                   directed_rows[r].window, directed_rows[r].typed,
                   directed_rows[r].average);
      pace_requests();
    end

    // stop and let the pipe go empty before the random traffic
    drain_responses();

    // Random traffic: about half adds, half queries. Clears are rare so the
    // write pointer gets to wrap. Unused codes are sprinkled in but are not
    // counted, since the block just drops them.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 199);
      if (pick < 2) c = rhwa_pkg::CMD_CLEAR;
      else if (pick < 4) c = CMD_UNUSED;
      else if (pick < 100) c = rhwa_pkg::CMD_ADD;
      else c = rhwa_pkg::CMD_QUERY;

      pick = $urandom_range(0, 19);
      if (pick < 14) s = {$urandom, $urandom};
      else if (pick < 17) s = rhwa_pkg::DATA_W'($urandom_range(0, 1000));
      else s = $urandom_range(0, 1) ? ALL_ONES : TOP_BIT;

      pick = $urandom_range(0, 24);
      if (pick < 20) w = rhwa_pkg::WIN_W'($urandom_range(1, 64));
      else if (pick < 22) w = $urandom_range(0, 1) ? 7'd0 : 7'd64;
      else w = rhwa_pkg::WIN_W'($urandom_range(65, 127));

      send_request(c, s, w, 1'b0, '0);
      if (c != CMD_UNUSED) sent++;

      // now and then the sender waits for every owed response
      if (sent % 500 == 250 && c != CMD_UNUSED) drain_responses();
      else pace_requests();
    end

    // all requests in: wait for the last responses, then a little longer to
    // catch anything stray
    req.valid <= 1'b0;
    @(posedge clk);
    while (owed_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && owed_averages.size() == 0) begin
      $display("rate_history_window_average_top verification clean");
    end else begin
      $display("rate_history_window_average_top verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Watchdog: worst case is every query a full-window one, each waiting
  // out a long response stall and a sender gap, well under 20 ms.
  // --------------------------------------------------------------------------
  initial begin
    #20_000_000;
    $display("%0t: watchdog expired, %0d responses still owed", $time, owed_averages.size());
    $display("rate_history_window_average_top verification failed");
    $finish;
  end

endmodule
